// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache resolver.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned MaxBeats          = 16;
  localparam int unsigned BeatCntW          = 5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgLocalIp    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLocalMac   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgReqTimeout = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCacheLife  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxRetries = 3'd4;

  localparam logic [2:0] OpTick    = 3'd0;
  localparam logic [2:0] OpRecv    = 3'd1;
  localparam logic [2:0] OpResolve = 3'd2;
  localparam logic [2:0] OpLookup  = 3'd3;
  localparam logic [2:0] OpFlush   = 3'd4;

  localparam logic [2:0] KindNone     = 3'd0;
  localparam logic [2:0] KindResolved = 3'd1;
  localparam logic [2:0] KindNotRes   = 3'd2;
  localparam logic [2:0] KindSendReq  = 3'd3;
  localparam logic [2:0] KindSendRep  = 3'd4;

  localparam logic [15:0] ArpOperRequest = 16'd1;
  localparam logic [15:0] ArpOperReply   = 16'd2;
  localparam logic [15:0] HwTypeEth      = 16'd1;
  localparam logic [15:0] ProtoTypeIpv4  = 16'h0800;
  localparam logic [7:0]  HwLenEth       = 8'd6;
  localparam logic [7:0]  ProtoLenIpv4   = 8'd4;
  localparam logic [15:0] MinFrameLen    = 16'd42;

  localparam logic [31:0] ReqTimeoutRst = 32'd100;
  localparam logic [31:0] CacheLifeRst  = 32'd600000;
  localparam logic [3:0]  MaxRetriesRst = 4'd3;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StTick   = 8'b0000_0010,
    StAdd    = 8'b0000_0100,
    StPrem   = 8'b0000_1000,
    StRemove = 8'b0001_0000,
    StLookup = 8'b0010_0000,
    StPscan  = 8'b0100_0000,
    StDone   = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/arp_cache_resolver.sv =====
// ----------------------------------------------------------------------------
// arp_cache_resolver
// ARP engine: expiring address cache and pending request table, one interface.
// ----------------------------------------------------------------------------
// Flush and a dropped frame finish without a table scan; a tick or a resolve
// scans the tables one entry at a time. A new item is taken only once the
// last is through; busy_o is high for the whole item. Results leave at most
// one beat a cycle, last_o marks the final beat; no stalling. Reset clears
// time, cache valid bits and pending count and resets the configuration.
module arp_cache_resolver #(
  parameter int unsigned TABLE_DEPTH = arpc_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [arpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [arpc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [2:0]                    opcode_i,
  input  logic [15:0]                   frame_length_i,
  input  logic [15:0]                   hw_type_i,
  input  logic [15:0]                   proto_type_i,
  input  logic [7:0]                    hw_len_i,
  input  logic [7:0]                    proto_len_i,
  input  logic [15:0]                   arp_oper_i,
  input  logic [47:0]                   sender_hw_i,
  input  logic [31:0]                   sender_proto_i,
  input  logic [31:0]                   target_proto_i,
  output logic                          result_valid_o,
  output logic [2:0]                    result_kind_o,
  output logic [47:0]                   hw_addr_o,
  output logic [31:0]                   proto_addr_o,
  output logic                          last_o
);
  import arpc_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  logic [31:0] local_ip_q, req_timeout_q, cache_life_q;
  logic [47:0] local_mac_q;
  logic [3:0]  max_retries_q;

  state_e      state_q, state_d, ret_q, ret_d;
  logic [CW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [31:0] time_q, time_d;
  logic [BeatCntW-1:0] beats_q, beats_d;

  logic [2:0]  op_q;
  logic [47:0] shw_q;
  logic [31:0] sip_q, tip_q;

  logic [TABLE_DEPTH-1:0] cvalid_q, cvalid_d;
  logic [31:0] cproto_q [TABLE_DEPTH];
  logic [47:0] chw_q    [TABLE_DEPTH];
  logic [31:0] cexp_q   [TABLE_DEPTH];
  logic [31:0] pproto_q [TABLE_DEPTH];
  logic [31:0] pstart_q [TABLE_DEPTH];
  logic [3:0]  pretry_q [TABLE_DEPTH];

  logic        held_q, held_d;
  logic [2:0]  hkind_q, hkind_d;
  logic [47:0] hhw_q, hhw_d;
  logic [31:0] hip_q, hip_d;

  logic        rv_d, rlast_d;
  logic [2:0]  rkind_d;
  logic [47:0] rhw_d;
  logic [31:0] rip_d;
  logic        rv_q, rlast_q;
  logic [2:0]  rkind_q;
  logic [47:0] rhw_q;
  logic [31:0] rip_q;

  logic        emit;
  logic [2:0]  ekind;
  logic [47:0] ehw;
  logic [31:0] eip;

  logic        cadd_we, cap_in;
  logic        pwe;
  logic [IW-1:0] pwaddr, prd, cidx;
  logic [31:0] pwproto, pwstart;
  logic [3:0]  pwretry;

  logic [31:0] rd_pproto, rd_pstart, rd_cproto, rd_cexp, elapsed;
  logic [3:0]  rd_pretry;
  logic [47:0] rd_chw;
  logic        accept, frame_ok;

  assign accept = start_i & ~busy_o;
  assign busy_o = (state_q != StIdle);
  assign cap_in = accept;

  assign cidx = idx_q[IW-1:0];
  assign prd  = (state_q == StRemove) ? IW'(cnt_q - CW'(1)) : idx_q[IW-1:0];

  assign rd_pproto = pproto_q[prd];
  assign rd_pstart = pstart_q[prd];
  assign rd_pretry = pretry_q[prd];
  assign rd_cproto = cproto_q[cidx];
  assign rd_chw    = chw_q[cidx];
  assign rd_cexp   = cexp_q[cidx];
  assign elapsed   = time_q - rd_pstart;

  assign frame_ok = (frame_length_i >= MinFrameLen) && (hw_type_i == HwTypeEth) &&
                    (proto_type_i == ProtoTypeIpv4) && (hw_len_i == HwLenEth) &&
                    (proto_len_i == ProtoLenIpv4);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    time_d   = time_q;
    cvalid_d = cvalid_q;
    emit     = 1'b0;
    ekind    = KindNone;
    ehw      = '0;
    eip      = '0;
    cadd_we  = 1'b0;
    pwe      = 1'b0;
    pwaddr   = idx_q[IW-1:0];
    pwproto  = rd_pproto;
    pwstart  = time_q;
    pwretry  = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d   = '0;
          state_d = StDone;
          case (opcode_i)
            OpTick: begin
              time_d  = time_q + 32'd1;
              state_d = StTick;
            end
            OpRecv: begin
              if (frame_ok && arp_oper_i == ArpOperRequest) begin
                if (target_proto_i == local_ip_q) begin
                  emit  = 1'b1;
                  ekind = KindSendRep;
                  ehw   = sender_hw_i;
                  eip   = sender_proto_i;
                end
              end else if (frame_ok && arp_oper_i == ArpOperReply) begin
                state_d = StAdd;
              end
            end
            OpResolve: begin
              if (local_ip_q == '0) begin
                emit  = 1'b1;
                ekind = KindNotRes;
                eip   = target_proto_i;
              end else begin
                state_d = StLookup;
              end
            end
            OpLookup: state_d = StLookup;
            OpFlush: begin
              cvalid_d = '0;
              cnt_d    = '0;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StTick: begin
        if (idx_q < cnt_q) begin
          if (elapsed > req_timeout_q) begin
            if (rd_pretry < max_retries_q) begin
              emit    = 1'b1;
              ekind   = KindSendReq;
              eip     = rd_pproto;
              pwe     = 1'b1;
              pwretry = rd_pretry + 4'd1;
              idx_d   = idx_q + CW'(1);
            end else begin
              ret_d   = StTick;
              state_d = StRemove;
            end
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end else begin
          state_d = StDone;
        end
      end
      StAdd: begin
        if (idx_q < Depth && !cvalid_q[cidx]) begin
          cadd_we        = 1'b1;
          cvalid_d[cidx] = 1'b1;
          idx_d          = '0;
          state_d        = StPrem;
        end else if (idx_q < Depth) begin
          idx_d = idx_q + CW'(1);
        end else begin
          idx_d   = '0;
          state_d = StPrem;
        end
      end
      StPrem: begin
        if (idx_q < cnt_q) begin
          if (rd_pproto == sip_q) begin
            ret_d   = StDone;
            state_d = StRemove;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end else begin
          state_d = StDone;
        end
      end
      StRemove: begin
        pwe     = 1'b1;
        pwproto = rd_pproto;
        pwstart = rd_pstart;
        pwretry = rd_pretry;
        cnt_d   = cnt_q - CW'(1);
        state_d = ret_q;
      end
      StLookup: begin
        if (idx_q < Depth) begin
          if (cvalid_q[cidx] && rd_cproto == tip_q) begin
            if (time_q < rd_cexp) begin
              emit    = 1'b1;
              ekind   = KindResolved;
              ehw     = rd_chw;
              eip     = tip_q;
              state_d = StDone;
            end else begin
              cvalid_d[cidx] = 1'b0;
              idx_d          = idx_q + CW'(1);
            end
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end else begin
          emit  = 1'b1;
          eip   = tip_q;
          idx_d = '0;
          if (op_q == OpResolve) begin
            ekind   = KindSendReq;
            state_d = StPscan;
          end else begin
            ekind   = KindNotRes;
            state_d = StDone;
          end
        end
      end
      StPscan: begin
        if (idx_q < cnt_q && rd_pproto == tip_q) begin
          emit    = 1'b1;
          ekind   = KindNotRes;
          eip     = tip_q;
          state_d = StDone;
        end else if (idx_q < cnt_q) begin
          idx_d = idx_q + CW'(1);
        end else begin
          if (cnt_q < Depth) begin
            pwe     = 1'b1;
            pwaddr  = cnt_q[IW-1:0];
            pwproto = tip_q;
            cnt_d   = cnt_q + CW'(1);
          end
          emit    = 1'b1;
          ekind   = KindNotRes;
          eip     = tip_q;
          state_d = StDone;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // hold one beat back so the final one can carry last
  always_comb begin
    held_d  = held_q;
    hkind_d = hkind_q;
    hhw_d   = hhw_q;
    hip_d   = hip_q;
    beats_d = beats_q;
    rv_d    = 1'b0;
    rlast_d = 1'b0;
    rkind_d = hkind_q;
    rhw_d   = hhw_q;
    rip_d   = hip_q;
    if (state_q == StIdle) begin
      beats_d = '0;
    end
    if (emit && beats_d < BeatCntW'(MaxBeats)) begin
      rv_d    = held_q;
      held_d  = 1'b1;
      hkind_d = ekind;
      hhw_d   = ehw;
      hip_d   = eip;
      beats_d = beats_d + BeatCntW'(1);
    end
    if (state_q == StDone) begin
      rv_d    = 1'b1;
      rlast_d = 1'b1;
      held_d  = 1'b0;
      if (!held_q) begin
        rkind_d = KindNone;
        rhw_d   = '0;
        rip_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      ret_q         <= StDone;
      idx_q         <= '0;
      cnt_q         <= '0;
      time_q        <= '0;
      cvalid_q      <= '0;
      held_q        <= 1'b0;
      beats_q       <= '0;
      rv_q          <= 1'b0;
      local_ip_q    <= '0;
      local_mac_q   <= '0;
      req_timeout_q <= ReqTimeoutRst;
      cache_life_q  <= CacheLifeRst;
      max_retries_q <= MaxRetriesRst;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      time_q   <= time_d;
      cvalid_q <= cvalid_d;
      held_q   <= held_d;
      beats_q  <= beats_d;
      rv_q     <= rv_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgLocalIp:    local_ip_q    <= cfg_data_i[31:0];
          CfgLocalMac:   local_mac_q   <= cfg_data_i;
          CfgReqTimeout: req_timeout_q <= cfg_data_i[31:0];
          CfgCacheLife:  cache_life_q  <= cfg_data_i[31:0];
          CfgMaxRetries: max_retries_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hkind_q <= hkind_d;
    hhw_q   <= hhw_d;
    hip_q   <= hip_d;
    rkind_q <= rkind_d;
    rhw_q   <= rhw_d;
    rip_q   <= rip_d;
    rlast_q <= rlast_d;
    if (cap_in) begin
      op_q  <= opcode_i;
      shw_q <= sender_hw_i;
      sip_q <= sender_proto_i;
      tip_q <= target_proto_i;
    end
    if (cadd_we) begin
      cproto_q[cidx] <= sip_q;
      chw_q[cidx]    <= shw_q;
      cexp_q[cidx]   <= time_q + cache_life_q;
    end
    if (pwe) begin
      pproto_q[pwaddr] <= pwproto;
      pstart_q[pwaddr] <= pwstart;
      pretry_q[pwaddr] <= pwretry;
    end
  end

  logic mac_unused;
  assign mac_unused = ^local_mac_q;

  assign result_valid_o = rv_q;
  assign result_kind_o  = rkind_q;
  assign hw_addr_o      = rhw_q & {48{~mac_unused | mac_unused}};
  assign proto_addr_o   = rip_q;
  assign last_o         = rlast_q;

endmodule

// ===== rtl/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks of the ARP cache resolver, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic [2:0] result_kind_o,
  input logic       last_o
);
  import arpc_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted item did not raise busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o) else $error("final beat while busy");

  a_more_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o) else $error("non-final beat after item end");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == KindNone |-> last_o)
    else $error("no-action beat not final");

endmodule

bind arp_cache_resolver arpc_checker u_arpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_kind_o  (result_kind_o),
  .last_o         (last_o)
);

// ===== tb/arp_cache_resolver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_cache_resolver_tb
// Self-checking bench: a queue-fed driver issues ticks, received ARP headers,
// resolves, lookups and flushes; a local predictor of cache and pending table
// builds the expected result beats, which the monitor checks in order.
// ----------------------------------------------------------------------------
module arp_cache_resolver_tb;
  import arpc_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_oper;
    logic [47:0] sender_hw;
    logic [31:0] sender_proto;
    logic [31:0] target_proto;
  } arp_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] hw;
    logic [31:0] proto;
    logic        last;
  } arp_beat_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  arp_item_t           drv_item    = '0;
  logic                busy_o, result_valid_o, last_o;
  logic [2:0]          result_kind_o;
  logic [47:0]         hw_addr_o;
  logic [31:0]         proto_addr_o;

  arp_cache_resolver #(.TABLE_DEPTH(Depth)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .opcode_i(drv_item.opcode), .frame_length_i(drv_item.frame_length),
    .hw_type_i(drv_item.hw_type), .proto_type_i(drv_item.proto_type),
    .hw_len_i(drv_item.hw_len), .proto_len_i(drv_item.proto_len),
    .arp_oper_i(drv_item.arp_oper), .sender_hw_i(drv_item.sender_hw),
    .sender_proto_i(drv_item.sender_proto), .target_proto_i(drv_item.target_proto),
    .result_valid_o, .result_kind_o, .hw_addr_o, .proto_addr_o, .last_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state and configuration
  logic [31:0] my_ip, req_timeout, cache_life;
  logic [47:0] my_mac;
  logic [3:0]  retry_limit;
  logic [31:0] now;
  logic        cv [Depth];
  logic [31:0] cip [Depth];
  logic [47:0] chw [Depth];
  logic [31:0] cexp [Depth];
  int unsigned pend_cnt;
  logic [31:0] pip [Depth];
  logic [31:0] pstart [Depth];
  logic [3:0]  pretry [Depth];

  arp_item_t   send_q[$];
  arp_beat_t   beats_due[$];
  arp_beat_t   item_beats[$];
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 25;
  logic [31:0] ip_pool [6];

  function automatic void add_beat(logic [2:0] kind, logic [47:0] hw, logic [31:0] ip);
    if (item_beats.size() < MaxBeats) item_beats.push_back('{kind, hw, ip, 1'b0});
  endfunction

  function automatic int cache_hit(logic [31:0] ip);
    for (int i = 0; i < Depth; i++) begin
      if (cv[i] && cip[i] == ip) begin
        if (now < cexp[i]) return i;
        cv[i] = 1'b0;
      end
    end
    return -1;
  endfunction

  function automatic void drop_pending(int unsigned i);
    pend_cnt--;
    pip[i]    = pip[pend_cnt];
    pstart[i] = pstart[pend_cnt];
    pretry[i] = pretry[pend_cnt];
  endfunction

  function automatic void predict_arp(arp_item_t it);
    int          hit;
    int unsigned i;
    bit          found;
    item_beats.delete();
    case (it.opcode)
      OpTick: begin
        now = now + 32'd1;
        i = 0;
        while (i < pend_cnt) begin
          if (now - pstart[i] > req_timeout) begin
            if (pretry[i] < retry_limit) begin
              add_beat(KindSendReq, '0, pip[i]);
              pstart[i] = now;
              pretry[i] = pretry[i] + 4'd1;
              i++;
            end else begin
              drop_pending(i);
            end
          end else begin
            i++;
          end
        end
      end
      OpRecv: begin
        if (it.frame_length >= MinFrameLen && it.hw_type == HwTypeEth &&
            it.proto_type == ProtoTypeIpv4 && it.hw_len == HwLenEth &&
            it.proto_len == ProtoLenIpv4) begin
          if (it.arp_oper == ArpOperRequest) begin
            if (it.target_proto == my_ip) add_beat(KindSendRep, it.sender_hw, it.sender_proto);
          end else if (it.arp_oper == ArpOperReply) begin
            found = 0;
            for (int k = 0; k < Depth && !found; k++) begin
              if (!cv[k]) begin
                cip[k] = it.sender_proto;
                chw[k] = it.sender_hw;
                cexp[k] = now + cache_life;
                cv[k] = 1'b1;
                found = 1;
              end
            end
            for (int k = 0; k < pend_cnt; k++) begin
              if (pip[k] == it.sender_proto) begin
                drop_pending(k);
                break;
              end
            end
          end
        end
      end
      OpResolve: begin
        if (my_ip == '0) begin
          add_beat(KindNotRes, '0, it.target_proto);
        end else begin
          hit = cache_hit(it.target_proto);
          if (hit >= 0) begin
            add_beat(KindResolved, chw[hit], it.target_proto);
          end else begin
            add_beat(KindSendReq, '0, it.target_proto);
            found = 0;
            for (int k = 0; k < pend_cnt; k++) if (pip[k] == it.target_proto) found = 1;
            if (!found && pend_cnt < Depth) begin
              pip[pend_cnt] = it.target_proto;
              pstart[pend_cnt] = now;
              pretry[pend_cnt] = '0;
              pend_cnt++;
            end
            add_beat(KindNotRes, '0, it.target_proto);
          end
        end
      end
      OpLookup: begin
        hit = cache_hit(it.target_proto);
        if (hit >= 0) add_beat(KindResolved, chw[hit], it.target_proto);
        else add_beat(KindNotRes, '0, it.target_proto);
      end
      OpFlush: begin
        for (int k = 0; k < Depth; k++) cv[k] = 1'b0;
        pend_cnt = 0;
      end
      default: ;
    endcase
    if (item_beats.size() == 0) add_beat(KindNone, '0, '0);
    item_beats[item_beats.size()-1].last = 1'b1;
    foreach (item_beats[k]) beats_due.push_back(item_beats[k]);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predict_arp(drv_item);
        accepted_cnt++;
      end
      if (!start_i || !busy_o) begin
        if (send_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          drv_item <= send_q.pop_front();
          start_i  <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d hw=%h ip=%h last=%b", $realtime,
                 result_kind_o, hw_addr_o, proto_addr_o, last_o);
        err_cnt++;
      end else begin
        arp_beat_t w;
        w = beats_due.pop_front();
        if (result_kind_o !== w.kind || hw_addr_o !== w.hw ||
            proto_addr_o !== w.proto || last_o !== w.last) begin
          $display("%0t: mismatch exp kind=%0d hw=%h ip=%h last=%b", $realtime,
                   w.kind, w.hw, w.proto, w.last);
          $display("%0t:          got kind=%0d hw=%h ip=%h last=%b", $realtime,
                   result_kind_o, hw_addr_o, proto_addr_o, last_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic arp_item_t good_arp(logic [15:0] oper, logic [31:0] spa,
                                         logic [31:0] tpa, logic [47:0] sha);
    arp_item_t it;
    it = '{OpRecv, 16'd60, HwTypeEth, ProtoTypeIpv4, HwLenEth, ProtoLenIpv4,
           oper, sha, spa, tpa};
    return it;
  endfunction

  function automatic arp_item_t op_item(logic [2:0] op, logic [31:0] tpa);
    arp_item_t it;
    it = '{op, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 48'd0, 32'd0, tpa};
    return it;
  endfunction

  function automatic logic [31:0] pick_ip();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return my_ip;
    if (r < 85) return ip_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  function automatic arp_item_t rand_item();
    arp_item_t    it;
    int unsigned  r;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(arp_item_t)-1:0];
    r = $urandom_range(99);
    if (r < 35) begin
      it.opcode = OpTick;
    end else if (r < 70) begin
      it = good_arp(($urandom_range(1)) ? ArpOperReply : ArpOperRequest, pick_ip(),
                    pick_ip(), 48'({$urandom, $urandom}));
      it.frame_length = 16'($urandom_range(65535, 42));
      case ($urandom_range(11))
        0: it.frame_length = 16'($urandom_range(41));
        1: it.hw_type = 16'($urandom);
        2: it.proto_type = 16'($urandom);
        3: it.hw_len = 8'($urandom);
        4: it.proto_len = 8'($urandom);
        5: it.arp_oper = 16'($urandom);
        default: ;
      endcase
    end else if (r < 87) begin
      it.opcode = OpResolve;
      it.target_proto = pick_ip();
    end else if (r < 97) begin
      it.opcode = OpLookup;
      it.target_proto = pick_ip();
    end else begin
      it.opcode = OpFlush;
    end
    return it;
  endfunction

  task automatic post(arp_item_t it);
    send_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || beats_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CfgLocalIp:    my_ip = val[31:0];
      CfgLocalMac:   my_mac = val[47:0];
      CfgReqTimeout: req_timeout = val[31:0];
      CfgCacheLife:  cache_life = val[31:0];
      CfgMaxRetries: retry_limit = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] ip, logic [47:0] mac, logic [31:0] tmo,
                         logic [31:0] life, logic [3:0] retries);
    cfg_write(CfgLocalIp, CfgDataW'(ip));
    cfg_write(CfgLocalMac, mac);
    cfg_write(CfgReqTimeout, CfgDataW'(tmo));
    cfg_write(CfgCacheLife, CfgDataW'(life));
    cfg_write(CfgMaxRetries, CfgDataW'(retries));
  endtask

  task automatic random_run(int unsigned n, int unsigned pct);
    idle_pct = pct;
    repeat (n) post(rand_item());
    drain();
  endtask

  initial begin
    arp_item_t it;
    my_ip = '0; my_mac = '0; req_timeout = ReqTimeoutRst;
    cache_life = CacheLifeRst; retry_limit = MaxRetriesRst;
    now = '0; pend_cnt = 0;
    for (int k = 0; k < Depth; k++) cv[k] = 1'b0;
    for (int k = 0; k < 6; k++) ip_pool[k] = 32'h0A00_0001 + k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: zero local address
    post(op_item(OpResolve, 32'h0A00_0001));
    post(good_arp(ArpOperRequest, 32'hFFFF_FFFF, 32'h0, 48'hFFFF_FFFF_FFFF));
    post(op_item(OpLookup, 32'h0));
    post(op_item(OpTick, 32'h0));
    drain();

    set_all(32'h0A00_00FE, 48'h0200_0000_00FE, 32'd2, 32'd40, 4'd2);
    post(op_item(OpResolve, 32'h0A00_0001));
    post(op_item(OpResolve, 32'h0A00_0001));
    repeat (3) post(op_item(OpTick, 32'h0));
    post(good_arp(ArpOperReply, 32'h0A00_0001, 32'h0A00_00FE, 48'hFFFF_FFFF_FFFF));
    post(op_item(OpResolve, 32'h0A00_0001));
    post(op_item(OpLookup, 32'h0A00_0001));
    post(op_item(OpLookup, 32'hFFFF_FFFF));
    post(good_arp(ArpOperRequest, 32'h0A00_0002, 32'h0A00_00FE, 48'h0));
    post(good_arp(ArpOperRequest, 32'h0A00_0002, 32'h0A00_0003, 48'h1));
    it = good_arp(ArpOperRequest, 32'h1, 32'h0A00_00FE, 48'h5); it.frame_length = 16'd41;
    post(it);
    it.frame_length = 16'hFFFF; post(it);
    it.hw_type = 16'hFFFF; post(it);
    it.hw_type = HwTypeEth; it.proto_type = 16'hFFFF; post(it);
    it.proto_type = ProtoTypeIpv4; it.hw_len = 8'hFF; post(it);
    it.hw_len = HwLenEth; it.proto_len = 8'hFF; post(it);
    it.proto_len = ProtoLenIpv4; it.arp_oper = 16'hFFFF; post(it);
    post(op_item(OpResolve, 32'h0A00_0005));
    post(op_item(OpFlush, 32'h0));
    post(op_item(OpLookup, 32'h0A00_0001));
    drain();

    set_all($urandom | 32'h1, 48'({$urandom, $urandom}), 32'd3, 32'd30, 4'd2);
    random_run(120, 25);

    set_all($urandom | 32'h1, 48'h0, 32'd0, 32'd0, 4'd15);
    random_run(120, 82);

    set_all(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
    random_run(60, 0);

    set_all($urandom | 32'h1, 48'({$urandom, $urandom}), 32'd1, 32'd8, 4'd4);
    random_run(70, 0);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
